FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds at an edge, consequent sequence starts at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("same-cycle implication check failed");

// Antecedent holds at an edge, consequent sequence starts at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("next-cycle implication check failed");

`endif

FILE: rtl/tpnsp_pkg.sv
// Shared widths, register codes and stage beat types of the spacing penalty core.
// No dependencies; imported by every module of the block.
`default_nettype none

package tpnsp_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int DIR_W     = 16;
  localparam int PORT_W    = 8;
  localparam int CROSS_W   = 16;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam int PEN_W     = 62;
  localparam int GRAD_W    = 40;

  // Internal widths
  localparam int SPAN_W    = 18;           // ports + 2*crossings
  localparam int S2_W      = 49;           // doubled spacing and doubled hinge
  localparam int DELTA_W   = COORD_W + 1;  // pin difference
  localparam int A2_W      = DELTA_W + 1;  // doubled absolute difference
  localparam int SQ_IN_W   = 32;           // hinge bits that feed the square
  localparam int SQ_W      = 2 * SQ_IN_W;
  localparam int GPROD_W   = 64;
  localparam int DIR_FRAC_BITS = 14;
  localparam int Q_W       = GPROD_W + 1 - DIR_FRAC_BITS;
  localparam int NUM_GRAD  = 4;

  localparam logic [GPROD_W:0] GRAD_ROUND = (GPROD_W+1)'(1) << (DIR_FRAC_BITS - 1);
  localparam logic [Q_W-1:0]   GRAD_NEG_LIM = Q_W'(1) << (GRAD_W - 1);
  localparam logic [Q_W-1:0]   GRAD_POS_LIM = (Q_W'(1) << (GRAD_W - 1)) - Q_W'(1);
  localparam logic [PEN_W-1:0] PEN_MAX = '1;

  // Gradient lane order
  localparam int G_X_PIN0 = 0;
  localparam int G_X_PIN1 = 1;
  localparam int G_Y_PIN0 = 2;
  localparam int G_Y_PIN1 = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEND_RADIUS = 1'b0,
    REG_CROSS_PITCH = 1'b1
  } cfg_reg_t;

  // One accepted net
  typedef struct packed {
    logic signed [COORD_W-1:0] pin0_x;
    logic signed [COORD_W-1:0] pin0_y;
    logic signed [COORD_W-1:0] pin1_x;
    logic signed [COORD_W-1:0] pin1_y;
    logic signed [DIR_W-1:0]   pin0_dir_x;
    logic signed [DIR_W-1:0]   pin0_dir_y;
    logic signed [DIR_W-1:0]   pin1_dir_x;
    logic signed [DIR_W-1:0]   pin1_dir_y;
    logic [PORT_W-1:0]         max_port_count;
    logic [CROSS_W-1:0]        crossing_count;
    logic                      net_enable;
    logic                      last_net;
  } net_beat_t;

  // Hinges and direction magnitudes, out of the spacing stages
  typedef struct packed {
    logic                             last;
    logic [S2_W-1:0]                  hx2;
    logic [S2_W-1:0]                  hy2;
    logic [NUM_GRAD-1:0][DIR_W-1:0]   dir_mag;
    logic [NUM_GRAD-1:0]              gneg;
  } hinge_beat_t;

  // Raw products, out of the multiply stage
  typedef struct packed {
    logic                             last;
    logic                             big;
    logic [SQ_W-1:0]                  sqx;
    logic [SQ_W-1:0]                  sqy;
    logic [NUM_GRAD-1:0][GPROD_W-1:0] gprod;
    logic [NUM_GRAD-1:0]              gneg;
  } prod_beat_t;

endpackage

`default_nettype wire

FILE: rtl/two_pin_net_spacing_penalty_core.sv
// Top level of the two-pin net spacing penalty core: configuration registers and stages.
// Depends on tpnsp_pkg, tpnsp_hinge, tpnsp_mult and tpnsp_sat.
//
// One net is taken on every clock cycle in which start is high and busy is low;
// busy is high only while rst is held. Each net yields exactly one result, shown
// for one cycle with done high, in the order the nets came in. The six register
// stages are: spacing product and pin deltas, spacing sum and absolute deltas,
// hinges, the 32x32 squares and 49x16 gradient products, rounding and clamping,
// and the output register. The receiver cannot stall, so the pipeline never
// holds. Write bend_radius (index 0) and cross_pitch (index 1) only while no
// net is in flight.
`default_nettype none

module two_pin_net_spacing_penalty_core import tpnsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_addr,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic signed [COORD_W-1:0] pin0_x,
  input  logic signed [COORD_W-1:0] pin0_y,
  input  logic signed [COORD_W-1:0] pin1_x,
  input  logic signed [COORD_W-1:0] pin1_y,
  input  logic signed [DIR_W-1:0]   pin0_dir_x,
  input  logic signed [DIR_W-1:0]   pin0_dir_y,
  input  logic signed [DIR_W-1:0]   pin1_dir_x,
  input  logic signed [DIR_W-1:0]   pin1_dir_y,
  input  logic [PORT_W-1:0]         max_port_count,
  input  logic [CROSS_W-1:0]        crossing_count,
  input  logic                      net_enable,
  input  logic                      last_net,
  output logic                      done,
  output logic [PEN_W-1:0]          penalty,
  output logic signed [GRAD_W-1:0]  grad_x_pin0,
  output logic signed [GRAD_W-1:0]  grad_x_pin1,
  output logic signed [GRAD_W-1:0]  grad_y_pin0,
  output logic signed [GRAD_W-1:0]  grad_y_pin1,
  output logic                      last_out
);

  logic [CFG_W-1:0]                bend_radius;
  logic [CFG_W-1:0]                cross_pitch;
  net_beat_t                       net;
  logic                            accept;
  logic                            hinge_valid;
  hinge_beat_t                     hinge_beat;
  logic                            prod_valid;
  prod_beat_t                      prod_beat;
  logic [NUM_GRAD-1:0][GRAD_W-1:0] grad;

  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bend_radius <= '0;
      cross_pitch <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BEND_RADIUS: bend_radius <= cfg_wdata;
        REG_CROSS_PITCH: cross_pitch <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Bundle the input beat
  always_comb begin
    net.pin0_x         = pin0_x;
    net.pin0_y         = pin0_y;
    net.pin1_x         = pin1_x;
    net.pin1_y         = pin1_y;
    net.pin0_dir_x     = pin0_dir_x;
    net.pin0_dir_y     = pin0_dir_y;
    net.pin1_dir_x     = pin1_dir_x;
    net.pin1_dir_y     = pin1_dir_y;
    net.max_port_count = max_port_count;
    net.crossing_count = crossing_count;
    net.net_enable     = net_enable;
    net.last_net       = last_net;
  end

  tpnsp_hinge u_hinge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .net         (net),
    .bend_radius (bend_radius),
    .cross_pitch (cross_pitch),
    .out_valid   (hinge_valid),
    .hb          (hinge_beat)
  );

  tpnsp_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hinge_valid),
    .hb        (hinge_beat),
    .out_valid (prod_valid),
    .pb        (prod_beat)
  );

  tpnsp_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .in_valid (prod_valid),
    .pb       (prod_beat),
    .done     (done),
    .penalty  (penalty),
    .grad     (grad),
    .last_out (last_out)
  );

  assign grad_x_pin0 = grad[G_X_PIN0];
  assign grad_x_pin1 = grad[G_X_PIN1];
  assign grad_y_pin0 = grad[G_Y_PIN0];
  assign grad_y_pin1 = grad[G_Y_PIN1];

endmodule

`default_nettype wire

FILE: rtl/tpnsp_hinge.sv
// Spacing and hinge stages (three register stages) of the spacing penalty core.
// Depends on tpnsp_pkg.
`default_nettype none

module tpnsp_hinge import tpnsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  net_beat_t          net,
  input  logic [CFG_W-1:0]   bend_radius,
  input  logic [CFG_W-1:0]   cross_pitch,
  output logic               out_valid,
  output hinge_beat_t        hb
);

  // Stage 1 registers
  logic                               s1_valid;
  logic [S2_W-1:0]                    s1_prod;
  logic [CFG_W:0]                     s1_r2;
  logic [DELTA_W-1:0]                 s1_dx;
  logic [DELTA_W-1:0]                 s1_dy;
  logic [NUM_GRAD-1:0][DIR_W-1:0]     s1_dir;
  logic                               s1_en;
  logic                               s1_last;

  // Stage 2 registers
  logic                               s2_valid;
  logic [S2_W-1:0]                    s2_sp;
  logic [A2_W-1:0]                    s2_ax2;
  logic [A2_W-1:0]                    s2_ay2;
  logic [NUM_GRAD-1:0][DIR_W-1:0]     s2_dmag;
  logic [NUM_GRAD-1:0]                s2_gneg;
  logic                               s2_en;
  logic                               s2_last;

  logic [SPAN_W-1:0]                  span;
  logic [DELTA_W-1:0]                 abs_dx;
  logic [DELTA_W-1:0]                 abs_dy;
  logic                               dx_pos;
  logic                               dy_pos;
  logic [NUM_GRAD-1:0][DIR_W-1:0]     dmag;
  logic [NUM_GRAD-1:0]                gneg;
  logic [S2_W-1:0]                    ax2_w;
  logic [S2_W-1:0]                    ay2_w;

  // Ports plus doubled crossings: doubling keeps the half port count exact
  assign span = SPAN_W'(net.max_port_count) + SPAN_W'({net.crossing_count, 1'b0});

  // Stage 1: spacing product and pin differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod <= S2_W'(cross_pitch) * S2_W'(span);
    s1_r2   <= {bend_radius, 1'b0};
    s1_dx   <= {net.pin0_x[COORD_W-1], net.pin0_x} - {net.pin1_x[COORD_W-1], net.pin1_x};
    s1_dy   <= {net.pin0_y[COORD_W-1], net.pin0_y} - {net.pin1_y[COORD_W-1], net.pin1_y};
    s1_dir[G_X_PIN0] <= net.pin0_dir_x;
    s1_dir[G_X_PIN1] <= net.pin1_dir_x;
    s1_dir[G_Y_PIN0] <= net.pin0_dir_y;
    s1_dir[G_Y_PIN1] <= net.pin1_dir_y;
    s1_en   <= net.net_enable;
    s1_last <= net.last_net;
  end

  // Absolute values, delta signs and gradient signs
  always_comb begin
    abs_dx = s1_dx[DELTA_W-1] ? (~s1_dx + DELTA_W'(1)) : s1_dx;
    abs_dy = s1_dy[DELTA_W-1] ? (~s1_dy + DELTA_W'(1)) : s1_dy;
    dx_pos = !s1_dx[DELTA_W-1] && (s1_dx != '0);
    dy_pos = !s1_dy[DELTA_W-1] && (s1_dy != '0);
    for (int i = 0; i < NUM_GRAD; i++) begin
      dmag[i] = s1_dir[i][DIR_W-1] ? (~s1_dir[i] + DIR_W'(1)) : s1_dir[i];
      gneg[i] = s1_dir[i][DIR_W-1] ^ ((i < G_Y_PIN0) ? dx_pos : dy_pos);
    end
  end

  // Stage 2: doubled spacing and doubled distances
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_sp   <= s1_prod + S2_W'(s1_r2);
    s2_ax2  <= {abs_dx, 1'b0};
    s2_ay2  <= {abs_dy, 1'b0};
    s2_dmag <= dmag;
    s2_gneg <= gneg;
    s2_en   <= s1_en;
    s2_last <= s1_last;
  end

  assign ax2_w = S2_W'(s2_ax2);
  assign ay2_w = S2_W'(s2_ay2);

  // Stage 3: hinges, forced to zero for a disabled net
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    hb.hx2     <= (s2_en && (s2_sp > ax2_w)) ? (s2_sp - ax2_w) : '0;
    hb.hy2     <= (s2_en && (s2_sp > ay2_w)) ? (s2_sp - ay2_w) : '0;
    hb.dir_mag <= s2_dmag;
    hb.gneg    <= s2_gneg;
    hb.last    <= s2_last;
  end

endmodule

`default_nettype wire

FILE: rtl/tpnsp_mult.sv
// Multiply stage of the spacing penalty core: hinge squares and gradient products.
// Depends on tpnsp_pkg.
`default_nettype none

module tpnsp_mult import tpnsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  hinge_beat_t hb,
  output logic        out_valid,
  output prod_beat_t  pb
);

  logic [SQ_IN_W-1:0] hx_lo;
  logic [SQ_IN_W-1:0] hy_lo;

  assign hx_lo = hb.hx2[SQ_IN_W-1:0];
  assign hy_lo = hb.hy2[SQ_IN_W-1:0];

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Square the hinges when both fit in 32 bits; flag saturation otherwise
  always_ff @(posedge clk) begin
    pb.sqx  <= SQ_W'(hx_lo) * SQ_W'(hx_lo);
    pb.sqy  <= SQ_W'(hy_lo) * SQ_W'(hy_lo);
    pb.big  <= (|hb.hx2[S2_W-1:SQ_IN_W]) || (|hb.hy2[S2_W-1:SQ_IN_W]);
    pb.gneg <= hb.gneg;
    pb.last <= hb.last;
    for (int i = 0; i < NUM_GRAD; i++) begin
      pb.gprod[i] <= GPROD_W'((i < G_Y_PIN0) ? hb.hx2 : hb.hy2) * GPROD_W'(hb.dir_mag[i]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpnsp_sat.sv
// Rounding, saturation and output register stages of the spacing penalty core.
// Depends on tpnsp_pkg.
`default_nettype none

module tpnsp_sat import tpnsp_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  prod_beat_t                     pb,
  output logic                           done,
  output logic [PEN_W-1:0]               penalty,
  output logic [NUM_GRAD-1:0][GRAD_W-1:0] grad,
  output logic                           last_out
);

  // Stage 5 registers
  logic                            s5_valid;
  logic [SQ_W:0]                   s5_psum;
  logic                            s5_big;
  logic                            s5_last;
  logic [NUM_GRAD-1:0][GRAD_W-1:0] s5_mag;
  logic [NUM_GRAD-1:0]             s5_neg;

  logic [NUM_GRAD-1:0][Q_W-1:0]    q;
  logic [NUM_GRAD-1:0][GRAD_W-1:0] mag;
  logic [GPROD_W:0]                rounded;

  // Round the gradient magnitudes to nearest and clamp by sign
  always_comb begin
    rounded = '0;
    for (int i = 0; i < NUM_GRAD; i++) begin
      rounded = {1'b0, pb.gprod[i]} + GRAD_ROUND;
      q[i]    = rounded[GPROD_W:DIR_FRAC_BITS];
      if (pb.gneg[i]) begin
        mag[i] = (q[i] > GRAD_NEG_LIM) ? GRAD_W'(GRAD_NEG_LIM) : GRAD_W'(q[i]);
      end else begin
        mag[i] = (q[i] > GRAD_POS_LIM) ? GRAD_W'(GRAD_POS_LIM) : GRAD_W'(q[i]);
      end
    end
  end

  // Stage 5: penalty sum and clamped magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_psum <= {1'b0, pb.sqx} + {1'b0, pb.sqy};
    s5_big  <= pb.big;
    s5_last <= pb.last;
    s5_mag  <= mag;
    s5_neg  <= pb.gneg;
  end

  // Stage 6: quarter and saturate the penalty, apply gradient signs
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    penalty  <= (s5_big || s5_psum[SQ_W]) ? PEN_MAX : s5_psum[SQ_W-1:2];
    last_out <= s5_last;
    for (int i = 0; i < NUM_GRAD; i++) begin
      grad[i] <= s5_neg[i] ? (~s5_mag[i] + GRAD_W'(1)) : s5_mag[i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpnsp_checker.sv
// Port-level checks of the spacing penalty core, bound to its top level.
// Depends on tpnsp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tpnsp_checker import tpnsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      net_enable,
  input  logic                      last_net,
  input  logic                      done,
  input  logic [PEN_W-1:0]          penalty,
  input  logic signed [GRAD_W-1:0]  grad_x_pin0,
  input  logic signed [GRAD_W-1:0]  grad_x_pin1,
  input  logic signed [GRAD_W-1:0]  grad_y_pin0,
  input  logic signed [GRAD_W-1:0]  grad_y_pin1,
  input  logic                      last_out
);

  logic res_zero;

  // Penalty and all four gradients at zero
  assign res_zero = (penalty == '0) && (grad_x_pin0 == '0) && (grad_x_pin1 == '0) &&
                    (grad_y_pin0 == '0) && (grad_y_pin1 == '0);

  // Every accepted net comes out as a result with done high
  `ASSERT_IMPLY(a_result_latency, clk, rst, start && !busy, ##6 done)

  // No result appears without a net taken before it
  `ASSERT_NEXT(a_no_spurious_result, clk, rst, !(start && !busy), ##5 !done)

  // A disabled net yields an all-zero result
  `ASSERT_IMPLY(a_disabled_zero, clk, rst, start && !busy && !net_enable, ##6 res_zero)

  // The batch marker travels with its net
  `ASSERT_IMPLY(a_last_follows, clk, rst, start && !busy, ##6 (last_out == $past(last_net, 6)))

endmodule

bind two_pin_net_spacing_penalty_core tpnsp_checker u_tpnsp_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for two_pin_net_spacing_penalty_core: directed nets, then random nets
// under several register settings, each checked against a built-in model or a fixed value.
// Depends on tpnsp_pkg and the core RTL only.

module tb;
  import tpnsp_pkg::*;

  localparam int ONE = 4096;  // 1.0 in coordinate fixed point
  localparam logic signed [GRAD_W-1:0] GRAD_TOP    = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GRAD_BOTTOM = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef struct packed {
    logic [PEN_W-1:0]         penalty;
    logic signed [GRAD_W-1:0] grad_x_pin0;
    logic signed [GRAD_W-1:0] grad_x_pin1;
    logic signed [GRAD_W-1:0] grad_y_pin0;
    logic signed [GRAD_W-1:0] grad_y_pin1;
    logic                     last;
  } penalty_res_t;

  typedef enum {ROW_CFG, ROW_NET} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    cfg_reg_t         reg_sel;
    logic [CFG_W-1:0] value;
    net_beat_t        net;
    bit               typed;
    penalty_res_t     want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             cfg_we = 1'b0;
  cfg_reg_t         cfg_addr = REG_BEND_RADIUS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  net_beat_t        net_in = '0;

  logic                     done;
  logic [PEN_W-1:0]         penalty;
  logic signed [GRAD_W-1:0] grad_x_pin0;
  logic signed [GRAD_W-1:0] grad_x_pin1;
  logic signed [GRAD_W-1:0] grad_y_pin0;
  logic signed [GRAD_W-1:0] grad_y_pin1;
  logic                     last_out;

  // Register copies for the model, and the results still owed by the core
  logic [CFG_W-1:0] bend_q = '0;
  logic [CFG_W-1:0] cross_q = '0;
  penalty_res_t     expected_results[$];
  stim_row_t        stim_rows[$];
  penalty_res_t     head;
  int               errors = 0;

  two_pin_net_spacing_penalty_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .pin0_x(net_in.pin0_x),
    .pin0_y(net_in.pin0_y),
    .pin1_x(net_in.pin1_x),
    .pin1_y(net_in.pin1_y),
    .pin0_dir_x(net_in.pin0_dir_x),
    .pin0_dir_y(net_in.pin0_dir_y),
    .pin1_dir_x(net_in.pin1_dir_x),
    .pin1_dir_y(net_in.pin1_dir_y),
    .max_port_count(net_in.max_port_count),
    .crossing_count(net_in.crossing_count),
    .net_enable(net_in.net_enable),
    .last_net(net_in.last_net),
    .done(done),
    .penalty(penalty),
    .grad_x_pin0(grad_x_pin0),
    .grad_x_pin1(grad_x_pin1),
    .grad_y_pin0(grad_y_pin0),
    .grad_y_pin1(grad_y_pin1),
    .last_out(last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Doubled hinge: doubled spacing minus doubled absolute delta, floored at zero
  function automatic logic [63:0] doubled_hinge(logic [63:0] s2, longint d);
    logic [63:0] a2;
    a2 = 64'(d < 0 ? -d : d) << 1;
    return (s2 > a2) ? s2 - a2 : 64'd0;
  endfunction

  // 2*h*dir*sgn in coordinate format: round the magnitude half up, sign it, clamp
  function automatic logic signed [GRAD_W-1:0] hinge_gradient(logic [63:0] h2,
                                                              logic signed [DIR_W-1:0] dir,
                                                              bit delta_pos);
    logic [79:0] q;
    int d;
    int m;
    bit neg;
    d = dir;
    m = (d < 0) ? -d : d;
    neg = (d < 0) ^ delta_pos;
    if (h2 == 0 || d == 0) return '0;
    q = (80'(h2) * 80'(m) + (80'd1 << (DIR_FRAC_BITS - 1))) >> DIR_FRAC_BITS;
    if (neg) begin
      if (q > (80'd1 << (GRAD_W - 1))) q = 80'd1 << (GRAD_W - 1);
      return GRAD_W'(80'd0 - q);
    end
    if (q > (80'd1 << (GRAD_W - 1)) - 80'd1) q = (80'd1 << (GRAD_W - 1)) - 80'd1;
    return GRAD_W'(q);
  endfunction

  // Penalty and gradients of one net under the current register copies
  function automatic penalty_res_t spacing_penalty_of(net_beat_t n);
    penalty_res_t r;
    logic [63:0] s2;
    logic [63:0] hx2;
    logic [63:0] hy2;
    logic [63:0] sqx;
    logic [63:0] sqy;
    logic [63:0] pen;
    longint dx;
    longint dy;
    r = '0;
    r.last = n.last_net;
    if (!n.net_enable) return r;
    // doubled spacing keeps the half port count exact
    s2 = 2 * 64'(bend_q) + 64'(cross_q) * (64'(n.max_port_count) + 2 * 64'(n.crossing_count));
    dx = longint'($signed(n.pin0_x)) - longint'($signed(n.pin1_x));
    dy = longint'($signed(n.pin0_y)) - longint'($signed(n.pin1_y));
    hx2 = doubled_hinge(s2, dx);
    hy2 = doubled_hinge(s2, dy);
    if (hx2 >= 64'h1_0000_0000 || hy2 >= 64'h1_0000_0000) begin
      pen = 64'(PEN_MAX);
    end else begin
      sqx = hx2 * hx2;
      sqy = hy2 * hy2;
      pen = (sqx >> 2) + (sqy >> 2) + (((sqx & 64'd3) + (sqy & 64'd3)) >> 2);
      if (pen > 64'(PEN_MAX)) pen = 64'(PEN_MAX);
    end
    r.penalty = pen[PEN_W-1:0];
    r.grad_x_pin0 = hinge_gradient(hx2, n.pin0_dir_x, dx > 0);
    r.grad_x_pin1 = hinge_gradient(hx2, n.pin1_dir_x, dx > 0);
    r.grad_y_pin0 = hinge_gradient(hy2, n.pin0_dir_y, dy > 0);
    r.grad_y_pin1 = hinge_gradient(hy2, n.pin1_dir_y, dy > 0);
    return r;
  endfunction

  function automatic net_beat_t mk_net(int p0x, int p0y, int p1x, int p1y,
                                       int d0x, int d0y, int d1x, int d1y,
                                       int ports, int crossings, bit en, bit last);
    net_beat_t n;
    n.pin0_x = COORD_W'(p0x);
    n.pin0_y = COORD_W'(p0y);
    n.pin1_x = COORD_W'(p1x);
    n.pin1_y = COORD_W'(p1y);
    n.pin0_dir_x = DIR_W'(d0x);
    n.pin0_dir_y = DIR_W'(d0y);
    n.pin1_dir_x = DIR_W'(d1x);
    n.pin1_dir_y = DIR_W'(d1y);
    n.max_port_count = PORT_W'(ports);
    n.crossing_count = CROSS_W'(crossings);
    n.net_enable = en;
    n.last_net = last;
    return n;
  endfunction

  function automatic penalty_res_t zero_res(bit last);
    penalty_res_t r;
    r = '0;
    r.last = last;
    return r;
  endfunction

  // Mostly within -1.0 to +1.0, now and then any 16-bit pattern
  function automatic logic signed [DIR_W-1:0] rand_dir();
    if ($urandom_range(0, 9) == 0) return DIR_W'($urandom);
    return DIR_W'($urandom_range(0, 32768) - 16384);
  endfunction

  // Spread of register values from tiny to full scale
  function automatic logic [CFG_W-1:0] rand_reg_value();
    case ($urandom_range(0, 3))
      0: return CFG_W'($urandom_range(0, 1 << 14));
      1: return CFG_W'($urandom_range(0, 1 << 20));
      2: return CFG_W'($urandom_range(0, 1 << 26));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // Second pin within about 1.5 spacings of the first, clamped to the coordinate range
  function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] base,
                                                          longint span);
    logic [63:0] rnd;
    longint off;
    longint v;
    rnd = {$urandom, $urandom};
    off = longint'(rnd % 64'(2 * span + 1)) - span;
    v = longint'(base) - off;
    if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return COORD_W'(v);
  endfunction

  task automatic add_cfg(cfg_reg_t sel, logic [CFG_W-1:0] v);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.value = v;
    row.net = '0;
    row.typed = 1'b0;
    row.want = '0;
    stim_rows.push_back(row);
  endtask

  task automatic add_net(net_beat_t n, bit typed = 1'b0, penalty_res_t want = '0);
    stim_row_t row;
    row.kind = ROW_NET;
    row.reg_sel = REG_BEND_RADIUS;
    row.value = '0;
    row.net = n;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  task automatic flag_error(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Offer one net, hold it until taken, then queue what it must produce
  task automatic drive_net(net_beat_t n, bit typed, penalty_res_t want);
    start <= 1'b1;
    net_in <= n;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(typed ? want : spacing_penalty_of(n));
  endtask

  // Drain the pipeline, then write one register
  task automatic set_register(cfg_reg_t sel, logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= sel;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == REG_BEND_RADIUS) bend_q = v;
    else cross_q = v;
  endtask

  // Check each result beat against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        flag_error("result beat with nothing pending");
      end else begin
        head = expected_results.pop_front();
        check_field("penalty", penalty, head.penalty);
        check_field("grad_x_pin0", grad_x_pin0, head.grad_x_pin0);
        check_field("grad_x_pin1", grad_x_pin1, head.grad_x_pin1);
        check_field("grad_y_pin0", grad_y_pin0, head.grad_y_pin0);
        check_field("grad_y_pin1", grad_y_pin1, head.grad_y_pin1);
        check_field("last_out", last_out, head.last);
      end
    end
  end

  initial begin
    penalty_res_t sat;
    net_beat_t n;
    longint span;
    int idle_pct;
    int drain;

    // Reset registers: zero spacing, so every hinge is zero
    add_net(mk_net(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   16384, -16384, -32768, 32767, 255, 65535, 1, 1), 1, zero_res(1));
    add_net(mk_net(0, 0, 0, 0, 16384, 16384, 16384, 16384, 0, 0, 1, 0), 1, zero_res(0));

    // Moderate spacing: deltas of both signs, half ports, odd directions
    add_cfg(REG_BEND_RADIUS, CFG_W'(4 * ONE));
    add_cfg(REG_CROSS_PITCH, CFG_W'(ONE));
    add_net(mk_net(0, 0, 0, 0, 16384, 16384, -16384, -16384, 2, 1, 1, 0));
    add_net(mk_net(2 * ONE, -3 * ONE, 0, 0, 8192, -8192, 12000, -5, 7, 0, 1, 1));
    add_net(mk_net(-1365, 5 * ONE, 0, 0, -32768, 32767, -32768, 32767, 1, 2, 1, 0));
    add_net(mk_net(ONE, ONE, 0, 0, 0, 0, 0, 0, 4, 0, 1, 0));
    // disabled net gives zeros but keeps the batch marker
    add_net(mk_net(0, 0, 0, 0, 16384, 16384, -16384, -16384, 2, 1, 0, 1), 1, zero_res(1));
    // x far apart, y close: only the y axis pushes
    add_net(mk_net(100 * ONE, ONE, 0, 0, 16384, -16384, 9000, -9000, 0, 3, 1, 0));
    add_net(mk_net(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   16384, -16384, 16384, -16384, 0, 0, 1, 1), 1, zero_res(1));

    // Full-scale registers: penalty pinned at its limit, gradients too on the first net
    add_cfg(REG_BEND_RADIUS, 31'h7fff_ffff);
    add_cfg(REG_CROSS_PITCH, 31'h7fff_ffff);
    sat = '0;
    sat.penalty = PEN_MAX;
    sat.grad_x_pin0 = GRAD_TOP;
    sat.grad_y_pin0 = GRAD_TOP;
    sat.grad_x_pin1 = GRAD_BOTTOM;
    sat.grad_y_pin1 = GRAD_BOTTOM;
    add_net(mk_net(0, 0, 0, 0, 16384, 16384, -16384, -16384, 255, 65535, 1, 0), 1, sat);
    add_net(mk_net(0, 0, 0, 0, 3, -3, 1, -1, 0, 0, 1, 0));
    add_net(mk_net(32'h7fff_ffff, 0, 32'h8000_0000, 0, 16384, 16384, 16384, 16384, 0, 0, 1, 0));

    // Hinge right at the edge of the square range
    add_cfg(REG_CROSS_PITCH, CFG_W'(1));
    add_net(mk_net(0, 0, 0, 0, 16384, -16384, 16384, -16384, 1, 0, 1, 0));
    add_net(mk_net(0, 0, 0, 0, 100, -100, 100, -100, 3, 0, 1, 1));
    add_net(mk_net(1, -1, 0, 0, 5, 5, -5, -5, 1, 0, 1, 0));

    // Smallest spacing: one LSB of radius, no crossing pitch
    add_cfg(REG_CROSS_PITCH, '0);
    add_cfg(REG_BEND_RADIUS, CFG_W'(1));
    add_net(mk_net(0, 0, 0, 0, 16384, 16384, 16384, 16384, 255, 65535, 1, 1));
    add_net(mk_net(1, 0, 0, 0, 16384, 16384, 16384, 16384, 0, 0, 1, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        set_register(stim_rows[i].reg_sel, stim_rows[i].value);
      end else begin
        drive_net(stim_rows[i].net, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random nets; each phase drains the pipeline before new register values
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 28 : (ph < 4) ? 45 : 0;
      if ($urandom_range(0, 1) == 0) begin
        set_register(REG_BEND_RADIUS, rand_reg_value());
        set_register(REG_CROSS_PITCH, rand_reg_value());
      end else begin
        set_register(REG_CROSS_PITCH, rand_reg_value());
        set_register(REG_BEND_RADIUS, rand_reg_value());
      end
      for (int k = 0; k < 165; k++) begin
        n.pin0_x = $urandom;
        n.pin0_y = $urandom;
        n.max_port_count = PORT_W'($urandom_range(0, 255));
        n.crossing_count = ($urandom_range(0, 4) == 0) ? CROSS_W'($urandom)
                                                       : CROSS_W'($urandom_range(0, 15));
        span = longint'(bend_q) + longint'(cross_q) *
               (longint'(n.max_port_count) / 2 + longint'(n.crossing_count));
        span = span + span / 2 + 1;
        // most pins land close enough for the hinge to bite
        if ($urandom_range(0, 9) < 7) begin
          n.pin1_x = near_coord(n.pin0_x, span);
          n.pin1_y = near_coord(n.pin0_y, span);
        end else begin
          n.pin1_x = $urandom;
          n.pin1_y = $urandom;
        end
        n.pin0_dir_x = rand_dir();
        n.pin0_dir_y = rand_dir();
        n.pin1_dir_x = rand_dir();
        n.pin1_dir_y = rand_dir();
        n.net_enable = ($urandom_range(0, 9) != 0);
        n.last_net = 1'($urandom_range(0, 1));
        drive_net(n, 1'b0, '0);
        // idle about idle_pct percent of the time
        while ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
      end
    end

    // Let the pipeline empty, then watch a little longer for stray beats
    start <= 1'b0;
    for (drain = 0; drain < 100 && expected_results.size() != 0; drain++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    if (errors == 0) begin
      $display("[two_pin_net_spacing_penalty_core] OK");
    end else begin
      $display("[two_pin_net_spacing_penalty_core] ERROR");
    end
    $finish;
  end

  // Hard stop if the core hangs
  initial begin
    #2_000_000;
    $display("[two_pin_net_spacing_penalty_core] ERROR");
    $finish;
  end

endmodule
